FILE: hdl/ach_pkg.sv
// ----------------------------------------------------------------------------
// ach_pkg: shared types and constants of the artifact context histogram
// Request classes, flag bit positions, queue depths and result layout.
// ----------------------------------------------------------------------------
`default_nettype none

package ach_pkg;

  // Counter table
  localparam int NUM_BINS        = 1024;
  localparam int BIN_W           = 10;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int RESULT_W        = 32;

  // Queue depths
  localparam int MID_DEPTH = 2;
  localparam int OUT_DEPTH = 4;

  // Register field widths and reset values
  localparam int INSERT_W = 30;
  localparam int MAPQ_W   = 8;
  localparam int BASEQ_W  = 7;
  localparam logic [INSERT_W-1:0] MIN_INSERT_RST = 30'd60;
  localparam logic [INSERT_W-1:0] MAX_INSERT_RST = 30'd600;
  localparam logic [MAPQ_W-1:0]   MIN_MAPQ_RST   = 8'd30;
  localparam logic [BASEQ_W-1:0]  MIN_BASEQ_RST  = 7'd20;

  // SAM flag bit positions
  localparam int FLAG_PAIRED    = 0;
  localparam int FLAG_UNMAPPED  = 2;
  localparam int FLAG_REVERSE   = 4;
  localparam int FLAG_READ1     = 6;
  localparam int FLAG_SECONDARY = 8;
  localparam int FLAG_QCFAIL    = 9;
  localparam int FLAG_DUP       = 10;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_MIN_INSERT = 2'd0,
    REG_MAX_INSERT = 2'd1,
    REG_MIN_MAPQ   = 2'd2,
    REG_MIN_BASEQ  = 2'd3
  } cfg_reg_t;

  // Request type field values
  localparam logic REQ_COUNT = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  // Classified command from front to back
  typedef enum logic [1:0] {
    OP_REJECT = 2'd0,
    OP_COUNT  = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [BIN_W-1:0] bin;
  } cmd_t;

  // Result transaction
  typedef struct packed {
    logic                counted;
    logic [BIN_W-1:0]    bin;
    logic [RESULT_W-1:0] count;
  } res_t;

  // One-hot nucleotide to {valid, 2-bit code}
  function automatic logic [2:0] base_code(input logic [3:0] nt);
    logic [2:0] r;
    unique case (nt)
      4'd1:    r = 3'b100;
      4'd2:    r = 3'b101;
      4'd4:    r = 3'b110;
      4'd8:    r = 3'b111;
      default: r = 3'b000;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/artifact_context_histogram_unit.sv
// ----------------------------------------------------------------------------
// artifact_context_histogram_unit: per-context base counter histogram
// Classifies aligned bases of paired reads and counts them into 1024
// saturating counters keyed by orientation, read base and reference context.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  -------   ---------------------  -------------------------------------------
//  request   push / full            req_type .. bin_select
//  result    empty / pop            counted, bin_used, bin_count
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  One request a cycle while full is low; each request passes classify,
//  queue, counter read and update before its result joins the result queue.
//  After reset the counter table is cleared with full held high;
//  configuration writes are taken throughout.
//  Requests keep flowing while results wait: the front stalls only when the
//  two-entry command queue is full or the table is being cleared, the back
//  when the four-entry result queue has no room.
// ----------------------------------------------------------------------------
`default_nettype none

module artifact_context_histogram_unit #(
  parameter int COUNT_WIDTH = ach_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic                          req_type,
  input  wire logic [11:0]                   read_flags,
  input  wire logic [7:0]                    map_quality,
  input  wire logic signed [30:0]            insert_size,
  input  wire logic [6:0]                    base_quality,
  input  wire logic [3:0]                    read_base,
  input  wire logic [3:0]                    ref_before,
  input  wire logic [3:0]                    ref_aligned,
  input  wire logic [3:0]                    ref_after,
  input  wire logic [ach_pkg::BIN_W-1:0]     bin_select,
  output logic                               empty,
  input  wire logic                          pop,
  output logic                               counted,
  output logic [ach_pkg::BIN_W-1:0]          bin_used,
  output logic [ach_pkg::RESULT_W-1:0]       bin_count,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [ach_pkg::INSERT_W-1:0]  cfg_data
);

  import ach_pkg::*;

  localparam int MCW = $clog2(MID_DEPTH+1);
  localparam int OCW = $clog2(OUT_DEPTH+1);

  cmd_t           front_cmd;
  cmd_t           mid_cmd;
  logic [$bits(cmd_t)-1:0] mid_rdata;
  logic           mid_empty;
  logic           mid_full;
  logic [MCW-1:0] mid_count;
  logic           cmd_pop;
  logic           clearing;
  logic           in_accept;

  logic           res_valid;
  res_t           back_res;
  res_t           out_res;
  logic [$bits(res_t)-1:0] out_rdata;
  logic [OCW-1:0] out_count;
  logic           out_full;

  assign full      = clearing || mid_full;
  assign in_accept = push && !full;

  // Front: configuration and classification
  ach_front u_front (
    .clk          (clk),
    .rst          (rst),
    .req_type     (req_type),
    .read_flags   (read_flags),
    .map_quality  (map_quality),
    .insert_size  (insert_size),
    .base_quality (base_quality),
    .read_base    (read_base),
    .ref_before   (ref_before),
    .ref_aligned  (ref_aligned),
    .ref_after    (ref_after),
    .bin_select   (bin_select),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg_ready    (cfg_ready),
    .cmd          (front_cmd)
  );

  // Command queue between front and back
  ach_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (in_accept),
    .wdata (front_cmd),
    .pop   (cmd_pop),
    .rdata (mid_rdata),
    .count (mid_count),
    .empty (mid_empty),
    .full  (mid_full)
  );

  assign mid_cmd = cmd_t'(mid_rdata);

  // Back: counter table
  ach_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!mid_empty),
    .cmd       (mid_cmd),
    .cmd_pop   (cmd_pop),
    .out_count (out_count),
    .res_valid (res_valid),
    .res       (back_res),
    .clearing  (clearing)
  );

  // Result queue
  ach_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_valid),
    .wdata (back_res),
    .pop   (pop),
    .rdata (out_rdata),
    .count (out_count),
    .empty (empty),
    .full  (out_full)
  );

  assign out_res   = res_t'(out_rdata);
  assign counted   = out_res.counted;
  assign bin_used  = out_res.bin;
  assign bin_count = out_res.count;

  // Checks
  a_no_result_drop: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !out_full)
    else $error("result transaction pushed into a full result queue");

  a_no_issue_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !cmd_pop && mid_count == '0)
    else $error("command issued or queued during the clearing pass");

  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> clearing && full)
    else $error("clearing pass not started after reset");

endmodule

`default_nettype wire

FILE: hdl/ach_ram.sv
// ----------------------------------------------------------------------------
// ach_ram: generic single-write, single-read RAM
// One write port, one read port, registered read data (read before write).
// ----------------------------------------------------------------------------
`default_nettype none

module ach_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hdl/ach_fifo.sv
// ----------------------------------------------------------------------------
// ach_fifo: small register FIFO
// Circular buffer of DEPTH entries with occupancy count; head shown directly.
// ----------------------------------------------------------------------------
`default_nettype none

module ach_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic                       pop,
  output logic      [WIDTH-1:0]           rdata,
  output logic      [$clog2(DEPTH+1)-1:0] count,
  output logic                            empty,
  output logic                            full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] buf_q [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = buf_q[rd_ptr];

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH-1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH-1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      buf_q[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ach_front.sv
// ----------------------------------------------------------------------------
// ach_front: configuration registers and request classifier
// Applies read and base filters and forms the counter index of each request.
// ----------------------------------------------------------------------------
`default_nettype none

module ach_front (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              req_type,
  input  wire logic [11:0]                       read_flags,
  input  wire logic [7:0]                        map_quality,
  input  wire logic signed [30:0]                insert_size,
  input  wire logic [6:0]                        base_quality,
  input  wire logic [3:0]                        read_base,
  input  wire logic [3:0]                        ref_before,
  input  wire logic [3:0]                        ref_aligned,
  input  wire logic [3:0]                        ref_after,
  input  wire logic [ach_pkg::BIN_W-1:0]         bin_select,
  input  wire logic                              cfg_valid,
  input  wire logic [1:0]                        cfg_index,
  input  wire logic [ach_pkg::INSERT_W-1:0]      cfg_data,
  output logic                                   cfg_ready,
  output ach_pkg::cmd_t                          cmd
);

  import ach_pkg::*;

  logic [INSERT_W-1:0] min_insert;
  logic [INSERT_W-1:0] max_insert;
  logic [MAPQ_W-1:0]   min_map_quality;
  logic [BASEQ_W-1:0]  min_base_quality;

  logic [30:0] isz_u;
  logic [30:0] mag;
  logic [2:0]  qb;
  logic [2:0]  rb;
  logic [2:0]  ra;
  logic [2:0]  rn;
  logic        flags_ok;
  logic        keep;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_insert       <= MIN_INSERT_RST;
      max_insert       <= MAX_INSERT_RST;
      min_map_quality  <= MIN_MAPQ_RST;
      min_base_quality <= MIN_BASEQ_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MIN_INSERT: min_insert       <= cfg_data;
        REG_MAX_INSERT: max_insert       <= cfg_data;
        REG_MIN_MAPQ:   min_map_quality  <= cfg_data[MAPQ_W-1:0];
        REG_MIN_BASEQ:  min_base_quality <= cfg_data[BASEQ_W-1:0];
      endcase
    end
  end

  // Absolute insert size; the most negative value maps onto 2^30
  assign isz_u = insert_size;
  assign mag   = isz_u[30] ? (~isz_u + 31'd1) : isz_u;

  assign qb = base_code(read_base);
  assign rb = base_code(ref_before);
  assign ra = base_code(ref_aligned);
  assign rn = base_code(ref_after);

  assign flags_ok = read_flags[FLAG_PAIRED] && !read_flags[FLAG_UNMAPPED] &&
                    !read_flags[FLAG_DUP] && !read_flags[FLAG_SECONDARY] &&
                    !read_flags[FLAG_QCFAIL];

  assign keep = flags_ok && (map_quality >= min_map_quality) &&
                (mag >= {1'b0, min_insert}) && (mag <= {1'b0, max_insert}) &&
                (base_quality >= min_base_quality) &&
                qb[2] && rb[2] && ra[2] && rn[2];

  // Command formation
  always_comb begin
    if (req_type == REQ_READ) begin
      cmd.op  = OP_READ;
      cmd.bin = bin_select;
    end else if (keep) begin
      cmd.op  = OP_COUNT;
      cmd.bin = {read_flags[FLAG_READ1], read_flags[FLAG_REVERSE],
                 qb[1:0], rb[1:0], ra[1:0], rn[1:0]};
    end else begin
      cmd.op  = OP_REJECT;
      cmd.bin = '0;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ach_back.sv
// ----------------------------------------------------------------------------
// ach_back: counter table and read-modify-write pipeline
// Clears the table after reset, then issues one command a cycle while the
// result queue has room, forwarding a write that lands on the read's edge.
// ----------------------------------------------------------------------------
`default_nettype none

module ach_back #(
  parameter int COUNT_WIDTH = ach_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cmd_valid,
  input  wire ach_pkg::cmd_t                          cmd,
  output logic                                        cmd_pop,
  input  wire logic [$clog2(ach_pkg::OUT_DEPTH+1)-1:0] out_count,
  output logic                                        res_valid,
  output ach_pkg::res_t                               res,
  output logic                                        clearing
);

  import ach_pkg::*;

  localparam int CW = $clog2(OUT_DEPTH+1);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  logic [BIN_W-1:0]       clr_addr;
  logic                   s1_valid;
  cmd_t                   s1_cmd;
  logic                   lw_valid;
  logic [BIN_W-1:0]       lw_addr;
  logic [COUNT_WIDTH-1:0] lw_data;

  logic [COUNT_WIDTH-1:0] rdata;
  logic [COUNT_WIDTH-1:0] cur;
  logic [COUNT_WIDTH-1:0] inc;
  logic [63:0]            cur_ext;
  logic [63:0]            inc_ext;
  logic                   we;
  logic [BIN_W-1:0]       waddr;
  logic [COUNT_WIDTH-1:0] wdata;

  // Issue only with room reserved in the output queue for the slot in flight
  assign cmd_pop = cmd_valid && !clearing &&
                   ((CW+1)'(out_count) + (CW+1)'(s1_valid) < (CW+1)'(OUT_DEPTH));

  // Clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + BIN_W'(1);
      if (clr_addr == BIN_W'(NUM_BINS-1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Read stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      lw_valid <= 1'b0;
    end else begin
      s1_valid <= cmd_pop;
      lw_valid <= we;
    end
  end

  always_ff @(posedge clk) begin
    s1_cmd  <= cmd;
    lw_addr <= waddr;
    lw_data <= wdata;
  end

  ach_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (NUM_BINS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (cmd.bin),
    .rdata (rdata)
  );

  // Update with forwarding and saturation
  assign cur     = (lw_valid && lw_addr == s1_cmd.bin) ? lw_data : rdata;
  assign inc     = (cur == CNT_MAX) ? cur : cur + COUNT_WIDTH'(1);
  assign cur_ext = 64'(cur);
  assign inc_ext = 64'(inc);

  assign we    = clearing || (s1_valid && s1_cmd.op == OP_COUNT);
  assign waddr = clearing ? clr_addr : s1_cmd.bin;
  assign wdata = clearing ? '0 : inc;

  // Result formation
  assign res_valid = s1_valid;
  always_comb begin
    unique case (s1_cmd.op)
      OP_COUNT: begin
        res.counted = 1'b1;
        res.bin     = s1_cmd.bin;
        res.count   = inc_ext[RESULT_W-1:0];
      end
      OP_READ: begin
        res.counted = 1'b0;
        res.bin     = s1_cmd.bin;
        res.count   = cur_ext[RESULT_W-1:0];
      end
      default: begin
        res.counted = 1'b0;
        res.bin     = '0;
        res.count   = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the artifact context histogram unit
// A queue-fed driver offers count and read requests. A clocked monitor pops
// results and compares each field with the oldest predicted transaction.
// The prediction keeps its own counter table and copy of the limit registers.
// Phases sweep the limits, the idle profiles and a long result back-pressure
// stall. A final burst hammers one counter back to back and reads it back.
// ----------------------------------------------------------------------------

module tb_top;
  import ach_pkg::*;

  // Counters narrower than the result field
  localparam int COUNT_W = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam int unsigned INSERT_TOP = (1 << INSERT_W) - 1;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int SAME_BIN_BURST = 40;
  localparam int DRAIN_CYCLES = 20;

  // One-hot nucleotide codes
  localparam logic [3:0] NT_A = 4'd1;
  localparam logic [3:0] NT_C = 4'd2;
  localparam logic [3:0] NT_G = 4'd4;
  localparam logic [3:0] NT_T = 4'd8;

  localparam logic [11:0] PAIRED_MASK = 12'd1 << FLAG_PAIRED;
  localparam logic [11:0] REJECT_MASK = (12'd1 << FLAG_UNMAPPED) | (12'd1 << FLAG_SECONDARY) |
                                        (12'd1 << FLAG_QCFAIL) | (12'd1 << FLAG_DUP);
  localparam logic [11:0] R1_REV = PAIRED_MASK | (12'd1 << FLAG_READ1) |
                                   (12'd1 << FLAG_REVERSE);

  typedef struct {
    logic                    req;
    logic [11:0]             flags;
    logic [7:0]              mapq;
    logic signed [30:0]      isz;
    logic [6:0]              bq;
    logic [3:0]              nt_read;
    logic [3:0]              nt_before;
    logic [3:0]              nt_aligned;
    logic [3:0]              nt_after;
    logic [BIN_W-1:0]        sel;
  } base_req_t;

  typedef struct {
    logic                counted;
    logic [BIN_W-1:0]    bin;
    logic [RESULT_W-1:0] count;
  } tally_t;

  // DUT ports
  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                push = 1'b0;
  logic                full;
  logic                req_type = 1'b0;
  logic [11:0]         read_flags = '0;
  logic [7:0]          map_quality = '0;
  logic signed [30:0]  insert_size = '0;
  logic [6:0]          base_quality = '0;
  logic [3:0]          read_base = '0;
  logic [3:0]          ref_before = '0;
  logic [3:0]          ref_aligned = '0;
  logic [3:0]          ref_after = '0;
  logic [BIN_W-1:0]    bin_select = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic                counted;
  logic [BIN_W-1:0]    bin_used;
  logic [RESULT_W-1:0] bin_count;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = '0;
  logic [INSERT_W-1:0] cfg_data = '0;

  // Predicted block state
  logic [COUNT_W-1:0]  bin_counts [NUM_BINS] = '{default: '0};
  logic [INSERT_W-1:0] cfg_min_insert = MIN_INSERT_RST;
  logic [INSERT_W-1:0] cfg_max_insert = MAX_INSERT_RST;
  logic [MAPQ_W-1:0]   cfg_min_mapq = MIN_MAPQ_RST;
  logic [BASEQ_W-1:0]  cfg_min_baseq = MIN_BASEQ_RST;

  base_req_t pending_bases[$];
  tally_t    expected_tallies[$];
  base_req_t offered;
  logic [BIN_W-1:0] last_bin = '0;
  int  tx_idle_pct = 0;
  int  rx_idle_pct = 0;
  bit  long_hold_armed = 1'b0;
  bit  long_hold_done = 1'b0;
  int  hold_count = 0;
  int  mismatch_count = 0;

  artifact_context_histogram_unit #(.COUNT_WIDTH(COUNT_W)) dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .req_type(req_type), .read_flags(read_flags), .map_quality(map_quality),
    .insert_size(insert_size), .base_quality(base_quality), .read_base(read_base),
    .ref_before(ref_before), .ref_aligned(ref_aligned), .ref_after(ref_after),
    .bin_select(bin_select), .empty(empty), .pop(pop), .counted(counted),
    .bin_used(bin_used), .bin_count(bin_count), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // {valid, 2-bit code} of a one-hot nucleotide
  function automatic logic [2:0] nt_to_code(logic [3:0] nt);
    case (nt)
      NT_A:    return 3'b100;
      NT_C:    return 3'b101;
      NT_G:    return 3'b110;
      NT_T:    return 3'b111;
      default: return 3'b000;
    endcase
  endfunction

  // Filter one request and update the predicted counter table
  function automatic tally_t tally_base(base_req_t b);
    tally_t t;
    logic [31:0] mag;
    logic [2:0] cq, cb, ca, cn;
    logic [BIN_W-1:0] idx;
    t = '{counted: 1'b0, bin: '0, count: '0};
    if (b.req == REQ_READ) begin
      t.bin = b.sel;
      t.count = RESULT_W'(bin_counts[b.sel]);
      return t;
    end
    mag = b.isz[30] ? (32'h8000_0000 - {1'b0, b.isz}) : {1'b0, b.isz};
    cq = nt_to_code(b.nt_read);
    cb = nt_to_code(b.nt_before);
    ca = nt_to_code(b.nt_aligned);
    cn = nt_to_code(b.nt_after);
    if (!b.flags[FLAG_PAIRED] || (b.flags & REJECT_MASK) != 0) return t;
    if (b.mapq < cfg_min_mapq) return t;
    if (mag < cfg_min_insert || mag > cfg_max_insert) return t;
    if (b.bq < cfg_min_baseq) return t;
    if (!(cq[2] && cb[2] && ca[2] && cn[2])) return t;
    idx = {b.flags[FLAG_READ1], b.flags[FLAG_REVERSE], cq[1:0], cb[1:0], ca[1:0], cn[1:0]};
    if (bin_counts[idx] != COUNT_MAX) bin_counts[idx] = bin_counts[idx] + 1'b1;
    t.counted = 1'b1;
    t.bin = idx;
    t.count = RESULT_W'(bin_counts[idx]);
    return t;
  endfunction

  function automatic logic signed [30:0] signed_insert(logic [30:0] mag);
    return $urandom_range(1) ? -mag : mag;
  endfunction

  function automatic base_req_t count_req(logic [11:0] flags, logic [7:0] mapq,
                                          logic signed [30:0] isz, logic [6:0] bq,
                                          logic [3:0] rd, logic [3:0] bf,
                                          logic [3:0] al, logic [3:0] af);
    base_req_t b;
    b = '{req: REQ_COUNT, flags: flags, mapq: mapq, isz: isz, bq: bq, nt_read: rd,
          nt_before: bf, nt_aligned: al, nt_after: af, sel: '0};
    return b;
  endfunction

  function automatic base_req_t read_req(logic [BIN_W-1:0] sel);
    base_req_t b;
    b = count_req(R1_REV, '0, '0, '0, NT_A, NT_A, NT_A, NT_A);
    b.req = REQ_READ;
    b.sel = sel;
    return b;
  endfunction

  // A base that passes the current limits if min insert <= max, often in a narrow context
  function automatic base_req_t good_base();
    base_req_t b;
    logic [30:0] mag;
    logic [2:0] cq, cb, ca, cn;
    b.req = REQ_COUNT;
    b.flags = (12'($urandom) & ~REJECT_MASK) | PAIRED_MASK;
    b.mapq = 8'($urandom_range(255, cfg_min_mapq));
    if (cfg_min_insert > cfg_max_insert) mag = 31'($urandom_range(INSERT_TOP));
    else if ($urandom_range(7) == 0)
      mag = 31'($urandom_range(1) ? cfg_min_insert : cfg_max_insert);
    else mag = 31'($urandom_range(cfg_max_insert, cfg_min_insert));
    b.isz = signed_insert(mag);
    b.bq = 7'($urandom_range(93, cfg_min_baseq));
    b.nt_read = NT_A << $urandom_range(3);
    b.nt_aligned = NT_A << $urandom_range(3);
    if ($urandom_range(1)) begin
      b.nt_before = NT_A;
      b.nt_after = NT_A;
    end else begin
      b.nt_before = NT_A << $urandom_range(3);
      b.nt_after = NT_A << $urandom_range(3);
    end
    b.sel = 10'($urandom);
    cq = nt_to_code(b.nt_read);
    cb = nt_to_code(b.nt_before);
    ca = nt_to_code(b.nt_aligned);
    cn = nt_to_code(b.nt_after);
    last_bin = {b.flags[FLAG_READ1], b.flags[FLAG_REVERSE], cq[1:0], cb[1:0], ca[1:0],
                cn[1:0]};
    return b;
  endfunction

  // Mix of well-formed bases, reads, single-filter violations and noise
  function automatic base_req_t random_base();
    base_req_t b;
    logic [3:0] bad_nt;
    int pick;
    pick = $urandom_range(99);
    b = good_base();
    if (pick < 15) begin
      b.req = REQ_READ;
      if ($urandom_range(1)) b.sel = 10'($urandom);
      else b.sel = last_bin;
    end else if (pick >= 70 && pick < 90) begin
      bad_nt = 4'($urandom);
      if (bad_nt == NT_A || bad_nt == NT_C || bad_nt == NT_G || bad_nt == NT_T)
        bad_nt = bad_nt | 4'b0011;
      case ($urandom_range(9))
        0: b.flags[FLAG_PAIRED] = 1'b0;
        1: b.flags[FLAG_UNMAPPED] = 1'b1;
        2: b.flags[FLAG_SECONDARY] = 1'b1;
        3: b.flags[FLAG_QCFAIL] = 1'b1;
        4: b.flags[FLAG_DUP] = 1'b1;
        5: if (cfg_min_mapq > 0) b.mapq = 8'($urandom_range(cfg_min_mapq - 1));
        6: if (cfg_min_insert > 0)
             b.isz = signed_insert(31'($urandom_range(cfg_min_insert - 1)));
        7: if (cfg_max_insert < INSERT_TOP)
             b.isz = signed_insert(31'($urandom_range(INSERT_TOP, cfg_max_insert + 1)));
           else b.isz = 31'h4000_0000;
        8: if (cfg_min_baseq > 0) b.bq = 7'($urandom_range(cfg_min_baseq - 1));
        default: case ($urandom_range(3))
          0: b.nt_read = bad_nt;
          1: b.nt_before = bad_nt;
          2: b.nt_aligned = bad_nt;
          default: b.nt_after = bad_nt;
        endcase
      endcase
    end else if (pick >= 90) begin
      b = '{req: 1'($urandom), flags: 12'($urandom), mapq: 8'($urandom),
            isz: 31'($urandom), bq: 7'($urandom_range(93)), nt_read: 4'($urandom),
            nt_before: 4'($urandom), nt_aligned: 4'($urandom), nt_after: 4'($urandom),
            sel: 10'($urandom)};
    end
    return b;
  endfunction

  // Request driver: one transaction per accepted push
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) expected_tallies.push_back(tally_base(offered));
      if (!push || !full) begin
        if (pending_bases.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          offered = pending_bases.pop_front();
          push <= 1'b1;
          req_type <= offered.req;
          read_flags <= offered.flags;
          map_quality <= offered.mapq;
          insert_size <= offered.isz;
          base_quality <= offered.bq;
          read_base <= offered.nt_read;
          ref_before <= offered.nt_before;
          ref_aligned <= offered.nt_aligned;
          ref_after <= offered.nt_after;
          bin_select <= offered.sel;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Result monitor and pop control
  always @(posedge clk) begin : result_check
    tally_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_tallies.size() == 0) begin
          $display("%0t: unexpected result, counted %0d bin %0d count %0d",
                   $time, counted, bin_used, bin_count);
          mismatch_count++;
        end else begin
          want = expected_tallies.pop_front();
          if (counted !== want.counted) begin
            $display("%0t: counted mismatch, expected %0d, actual %0d",
                     $time, want.counted, counted);
            mismatch_count++;
          end
          if (bin_used !== want.bin) begin
            $display("%0t: bin_used mismatch, expected %0d, actual %0d",
                     $time, want.bin, bin_used);
            mismatch_count++;
          end
          if (bin_count !== want.count) begin
            $display("%0t: bin_count mismatch, expected %0d, actual %0d",
                     $time, want.count, bin_count);
            mismatch_count++;
          end
        end
      end
      // long back-pressure stretch, counted here
      if (long_hold_armed && !long_hold_done) begin
        pop <= 1'b0;
        hold_count++;
        if (hold_count >= LONG_HOLD_CYCLES) long_hold_done = 1'b1;
      end else begin
        pop <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Wait until nothing is queued, offered or outstanding
  task automatic wait_idle();
    while (!(pending_bases.size() == 0 && !push && expected_tallies.size() == 0))
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [INSERT_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MIN_INSERT: cfg_min_insert = val;
      REG_MAX_INSERT: cfg_max_insert = val;
      REG_MIN_MAPQ:   cfg_min_mapq = val[MAPQ_W-1:0];
      REG_MIN_BASEQ:  cfg_min_baseq = val[BASEQ_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_limits(int unsigned min_ins, int unsigned max_ins,
                            int unsigned min_mq, int unsigned min_bq);
    write_reg(REG_MIN_INSERT, INSERT_W'(min_ins));
    write_reg(REG_MAX_INSERT, INSERT_W'(max_ins));
    write_reg(REG_MIN_MAPQ, INSERT_W'(min_mq));
    write_reg(REG_MIN_BASEQ, INSERT_W'(min_bq));
  endtask

  task automatic run_random(int n);
    repeat (n) pending_bases.push_back(random_base());
    wait_idle();
  endtask

  // Run limit
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // Sequencer
  initial begin : sequencer
    int unsigned lo;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed checks at the reset limits
    pending_bases.push_back(count_req(R1_REV, 30, 60, 20, NT_A, NT_A, NT_A, NT_A));
    pending_bases.push_back(count_req(R1_REV, 255, -600, 93, NT_A, NT_A, NT_A, NT_A));
    pending_bases.push_back(count_req(R1_REV, 30, 59, 20, NT_A, NT_A, NT_A, NT_A));
    pending_bases.push_back(count_req(R1_REV, 30, -601, 20, NT_A, NT_A, NT_A, NT_A));
    pending_bases.push_back(count_req(R1_REV, 29, 100, 20, NT_A, NT_A, NT_A, NT_A));
    pending_bases.push_back(count_req(R1_REV, 30, 100, 19, NT_A, NT_A, NT_A, NT_A));
    pending_bases.push_back(count_req(R1_REV & ~PAIRED_MASK, 30, 100, 20,
                                      NT_A, NT_A, NT_A, NT_A));
    pending_bases.push_back(count_req(R1_REV | (12'd1 << FLAG_UNMAPPED), 30, 100, 20,
                                      NT_A, NT_A, NT_A, NT_A));
    pending_bases.push_back(count_req(R1_REV | (12'd1 << FLAG_SECONDARY), 30, 100, 20,
                                      NT_A, NT_A, NT_A, NT_A));
    pending_bases.push_back(count_req(R1_REV | (12'd1 << FLAG_QCFAIL), 30, 100, 20,
                                      NT_A, NT_A, NT_A, NT_A));
    pending_bases.push_back(count_req(R1_REV | (12'd1 << FLAG_DUP), 30, 100, 20,
                                      NT_A, NT_A, NT_A, NT_A));
    // ambiguous or invalid nucleotide codes
    pending_bases.push_back(count_req(R1_REV, 30, 100, 20, 4'hF, NT_A, NT_A, NT_A));
    pending_bases.push_back(count_req(R1_REV, 30, 100, 20, NT_A, 4'h0, NT_A, NT_A));
    pending_bases.push_back(count_req(R1_REV, 30, 100, 20, NT_A, NT_A, 4'h6, NT_A));
    pending_bases.push_back(count_req(R1_REV, 30, 100, 20, NT_A, NT_A, NT_A, 4'h3));
    // insert size extremes
    pending_bases.push_back(count_req(R1_REV, 30, -(2**30), 20, NT_A, NT_A, NT_A, NT_A));
    pending_bases.push_back(count_req(R1_REV, 30, 2**30 - 1, 20, NT_A, NT_A, NT_A, NT_A));
    // orientation extremes and every non-rejecting flag bit set
    pending_bases.push_back(count_req(PAIRED_MASK, 30, 100, 20, NT_T, NT_T, NT_T, NT_T));
    pending_bases.push_back(count_req(R1_REV, 30, 100, 20, NT_T, NT_T, NT_T, NT_T));
    pending_bases.push_back(count_req(12'hFFF & ~REJECT_MASK, 255, 600, 93,
                                      NT_C, NT_G, NT_T, NT_A));
    pending_bases.push_back(read_req(10'd768));
    pending_bases.push_back(read_req(10'd1023));
    pending_bases.push_back(read_req(10'd0));
    pending_bases.push_back(read_req(10'd255));
    wait_idle();

    // sender sparse idling, receiver heavy idling
    tx_idle_pct = 13;
    rx_idle_pct = 51;
    run_random(180);
    // wide-open limits, with a long receiver stall to fill the block
    set_limits(0, INSERT_TOP, 0, 0);
    long_hold_armed = 1'b1;
    run_random(180);

    // roles swapped
    tx_idle_pct = 51;
    rx_idle_pct = 13;
    // inverted insert window and strictest qualities: nothing counts
    set_limits(1000, 10, 255, 93);
    run_random(180);
    lo = $urandom_range(2000);
    set_limits(lo, lo + $urandom_range(5000), $urandom_range(60), $urandom_range(40));
    run_random(180);

    // no idling
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    lo = $urandom_range(INSERT_TOP);
    set_limits(lo, lo, $urandom_range(255), $urandom_range(93));
    run_random(180);
    set_limits(MIN_INSERT_RST, MAX_INSERT_RST, MIN_MAPQ_RST, MIN_BASEQ_RST);
    run_random(150);

    // hammer one counter back to back, then read it back
    repeat (SAME_BIN_BURST)
      pending_bases.push_back(count_req(PAIRED_MASK, 60, -300, 40, NT_G, NT_C, NT_A, NT_T));
    pending_bases.push_back(read_req(10'b00_10_01_00_11));
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
